// File: rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SWK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/swk_pkg.sv
`default_nettype none
package swk_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int SQRT_BITS = 26;
  localparam int STW = $clog2(SQRT_BITS);
  localparam int DIV_BITS = 12;
  localparam int DBW = $clog2(DIV_BITS);
  localparam int VW = 26;
  localparam int CW = 44;
  localparam int ZW = 27;
  localparam int RW = 2 * VW - 1;
  localparam int DVW = 34;
  localparam int FW = 22;
  localparam int PW = 41;

  localparam logic signed [ZW-1:0] DEG90 = ZW'(90 * 65536);
  localparam logic signed [ZW-1:0] DEG180 = ZW'(180 * 65536);
  localparam logic signed [ZW-1:0] DEG360 = ZW'(360 * 65536);

  localparam logic [2:0] REG_HALF_WB = 3'd0;
  localparam logic [2:0] REG_HALF_TR = 3'd1;
  localparam logic [2:0] REG_FULL_SPD = 3'd2;
  localparam logic [2:0] REG_CENTRE = 3'd3;
  localparam logic [2:0] REG_DEAD = 3'd4;
  localparam logic [2:0] REG_LOWEST = 3'd5;
  localparam logic [2:0] REG_HIGHEST = 3'd6;
  localparam logic [2:0] REG_STEPS = 3'd7;

  // arctangent of 2^-i in q16 degrees
  function automatic logic [21:0] atan_of(input logic [STW-1:0] s);
    logic [21:0] a;
    case (s)
      5'd0: a = 22'd2949120;
      5'd1: a = 22'd1740967;
      5'd2: a = 22'd919880;
      5'd3: a = 22'd466945;
      5'd4: a = 22'd234380;
      5'd5: a = 22'd117304;
      5'd6: a = 22'd58666;
      5'd7: a = 22'd29335;
      5'd8: a = 22'd14668;
      5'd9: a = 22'd7334;
      5'd10: a = 22'd3667;
      5'd11: a = 22'd1833;
      5'd12: a = 22'd917;
      5'd13: a = 22'd458;
      5'd14: a = 22'd229;
      5'd15: a = 22'd115;
      5'd16: a = 22'd57;
      5'd17: a = 22'd29;
      5'd18: a = 22'd14;
      5'd19: a = 22'd7;
      5'd20: a = 22'd4;
      5'd21: a = 22'd2;
      5'd22: a = 22'd1;
      default: a = 22'd0;
    endcase
    return a;
  endfunction

  typedef struct packed {
    logic vld;
    logic [1:0] wheel;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [ZW-1:0] cz;
    logic hold;
    logic [RW-1:0] rem;
    logic [SQRT_BITS-1:0] root;
  } cell_t;

  typedef struct packed {
    logic [1:0] wheel;
    logic rev;
    logic tneg;
    logic [PW-1:0] sprod;
    logic [13:0] cdeg_mag;
    logic over;
    logic span_neg;
    logic signed [13:0] base;
  } res_t;

  typedef struct packed {
    logic vld;
    res_t res;
    logic [DVW-1:0] rem;
    logic [DIV_BITS-1:0] quo;
  } div_t;

endpackage
`default_nettype wire

// File: rtl/core/swk_cell.sv
`default_nettype none
module swk_cell (
  input wire logic clk,
  input wire logic rst,
  input wire logic [swk_pkg::STW-1:0] stage,
  input wire logic rot_en,
  input wire swk_pkg::cell_t din,
  output swk_pkg::cell_t dout
);
  import swk_pkg::*;

  logic signed [CW-1:0] xin, yin, dx, dy;
  logic signed [ZW-1:0] at;
  logic [STW-1:0] bpos;
  logic [RW-1:0] trial;
  cell_t nxt;

  always_comb begin
    nxt = din;
    xin = din.cx;
    yin = din.cy;
    dx = yin >>> stage;
    dy = xin >>> stage;
    at = ZW'(atan_of(stage));
    // one micro-rotation toward the x axis
    if (rot_en && !din.hold) begin
      if (yin > 0) begin
        nxt.cx = xin + dx;
        nxt.cy = yin - dy;
        nxt.cz = din.cz + at;
      end else begin
        nxt.cx = xin - dx;
        nxt.cy = yin + dy;
        nxt.cz = din.cz - at;
      end
    end
    // one root bit: (r + 2^b)^2 - r^2
    bpos = STW'(SQRT_BITS - 1) - stage;
    trial = (RW'(din.root) << (bpos + STW'(1))) | (RW'(1) << {bpos, 1'b0});
    if (din.rem >= trial) begin
      nxt.rem = din.rem - trial;
      nxt.root = din.root | (SQRT_BITS'(1) << bpos);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout <= nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/swk_div_cell.sv
`default_nettype none
module swk_div_cell (
  input wire logic clk,
  input wire logic rst,
  input wire logic [swk_pkg::DBW-1:0] bit_idx,
  input wire logic [swk_pkg::FW-1:0] divisor,
  input wire swk_pkg::div_t din,
  output swk_pkg::div_t dout
);
  import swk_pkg::*;

  logic [DVW-1:0] dsh;
  div_t nxt;

  always_comb begin
    nxt = din;
    dsh = DVW'(divisor) << bit_idx;
    if (din.rem >= dsh) begin
      nxt.rem = din.rem - dsh;
      nxt.quo = din.quo | (DIV_BITS'(1) << bit_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout <= nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/swerve_wheel_command.sv
`default_nettype none
`include "assert_macros.svh"
// four-wheel swerve inverse kinematics
// a command (vel_x, vel_y, yaw_rate) is taken at a rising edge with start high
// and busy low. busy then stays high until the last wheel of the command is
// issued, when a new command can be taken: the wheels of one command share a
// single pipeline, one wheel entering per cycle.
// each command gives four results in order left front, right front, left rear,
// right rear, on consecutive cycles, each marked by strobe for one cycle;
// last_wheel marks the fourth.
// the pipeline is a row of 26 cells, each doing one square-root bit, the first
// 16 also doing one cordic rotation, then a row of 12 cells forming the drive
// pulse quotient. the receiver cannot stall; results are simply presented.
// registers are written over the apb port; the user must do so only while no
// transaction is in flight, which the block does not enforce. reset clears the
// pipeline and loads the default geometry and pulse settings.
module swerve_wheel_command (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic signed [12:0] vel_x,
  input wire logic signed [12:0] vel_y,
  input wire logic signed [13:0] yaw_rate,
  output logic busy,
  output logic strobe,
  output logic [1:0] wheel_index,
  output logic last_wheel,
  output logic signed [15:0] steer_target_steps,
  output logic signed [14:0] steer_angle_cdeg,
  output logic [11:0] drive_pulse_us,
  output logic drive_reversed,
  input wire logic psel,
  input wire logic penable,
  input wire logic pwrite,
  input wire logic [4:0] paddr,
  input wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import swk_pkg::*;

  // configuration
  logic [10:0] half_wb, half_tr, centre, lowest;
  logic [11:0] full_spd, highest;
  logic [8:0] dead;
  logic [17:0] steps_q8;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_wb <= 11'd330;
      half_tr <= 11'd280;
      full_spd <= 12'd1000;
      centre <= 11'd1500;
      dead <= 9'd80;
      lowest <= 11'd1000;
      highest <= 12'd2000;
      steps_q8 <= 18'd45509;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_HALF_WB: half_wb <= pwdata[10:0];
        REG_HALF_TR: half_tr <= pwdata[10:0];
        REG_FULL_SPD: full_spd <= pwdata[11:0];
        REG_CENTRE: centre <= pwdata[10:0];
        REG_DEAD: dead <= pwdata[8:0];
        REG_LOWEST: lowest <= pwdata[10:0];
        REG_HIGHEST: highest <= pwdata[11:0];
        REG_STEPS: steps_q8 <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_HALF_WB: prdata = 32'(half_wb);
      REG_HALF_TR: prdata = 32'(half_tr);
      REG_FULL_SPD: prdata = 32'(full_spd);
      REG_CENTRE: prdata = 32'(centre);
      REG_DEAD: prdata = 32'(dead);
      REG_LOWEST: prdata = 32'(lowest);
      REG_HIGHEST: prdata = 32'(highest);
      REG_STEPS: prdata = 32'(steps_q8);
      default: prdata = 32'd0;
    endcase
  end

  // full speed in um/s, zero acts as one
  logic [11:0] fs;
  logic [FW-1:0] full_u;
  assign fs = (full_spd == 12'd0) ? 12'd1 : full_spd;
  assign full_u = FW'(fs) * FW'(1000);

  // command intake and wheel issue
  logic signed [12:0] cmd_vx, cmd_vy;
  logic signed [13:0] cmd_yr;
  logic active;
  logic [1:0] cnt;
  logic accept;

  assign busy = active && (cnt != 2'd3);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt <= 2'd0;
    end else if (accept) begin
      active <= 1'b1;
      cnt <= 2'd0;
    end else if (active) begin
      if (cnt == 2'd3) begin
        active <= 1'b0;
      end else begin
        cnt <= cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_vx <= vel_x;
      cmd_vy <= vel_y;
      cmd_yr <= yaw_rate;
    end
  end

  // stage a: products
  logic signed [VW-1:0] yr_e, hw_e, ht_e;
  logic a_vld;
  logic [1:0] a_wheel;
  logic signed [VW-1:0] a_px, a_py, a_pw, a_pt;

  assign yr_e = VW'(cmd_yr);
  assign hw_e = $signed({{(VW - 11){1'b0}}, half_wb});
  assign ht_e = $signed({{(VW - 11){1'b0}}, half_tr});

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= active;
    end
  end

  always_ff @(posedge clk) begin
    a_wheel <= cnt;
    a_px <= VW'(cmd_vx) * VW'(1000);
    a_py <= VW'(cmd_vy) * VW'(1000);
    a_pw <= yr_e * hw_e;
    a_pt <= yr_e * ht_e;
  end

  // stage b: wheel velocity in um/s
  logic b_vld;
  logic [1:0] b_wheel;
  logic signed [VW-1:0] b_wx, b_wy;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    b_wheel <= a_wheel;
    b_wx <= a_wheel[0] ? (a_px + a_pt) : (a_px - a_pt);
    b_wy <= a_wheel[1] ? (a_py - a_pw) : (a_py + a_pw);
  end

  // stage c: squares and cordic start point
  logic signed [2*VW-1:0] sqx, sqy;
  logic signed [VW-1:0] xs, ys;
  logic signed [CW-1:0] init_cx, init_cy;
  logic signed [ZW-1:0] init_cz;
  logic init_hold;

  assign sqx = b_wx * b_wx;
  assign sqy = b_wy * b_wy;

  always_comb begin
    xs = (b_wx < 0) ? -b_wx : b_wx;
    ys = (b_wx < 0) ? -b_wy : b_wy;
    init_cx = {{(CW - VW - 16){xs[VW-1]}}, xs, 16'b0};
    init_cy = {{(CW - VW - 16){ys[VW-1]}}, ys, 16'b0};
    init_hold = 1'b1;
    // on-axis headings are exact
    if (b_wy == 0) begin
      init_cz = (b_wx < 0) ? DEG180 : '0;
    end else if (b_wx == 0) begin
      init_cz = (b_wy > 0) ? DEG90 : -DEG90;
    end else begin
      init_hold = 1'b0;
      if (b_wx < 0) begin
        init_cz = (b_wy > 0) ? DEG180 : -DEG180;
      end else begin
        init_cz = '0;
      end
    end
  end

  logic c_vld;
  logic [1:0] c_wheel;
  logic [RW-2:0] c_sqx, c_sqy;
  logic signed [CW-1:0] c_cx, c_cy;
  logic signed [ZW-1:0] c_cz;
  logic c_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    c_wheel <= b_wheel;
    c_sqx <= sqx[RW-2:0];
    c_sqy <= sqy[RW-2:0];
    c_cx <= init_cx;
    c_cy <= init_cy;
    c_cz <= init_cz;
    c_hold <= init_hold;
  end

  // cell row: cordic heading and square root side by side
  cell_t cell_in;
  cell_t cch [0:SQRT_BITS];

  always_comb begin
    cell_in.vld = c_vld;
    cell_in.wheel = c_wheel;
    cell_in.cx = c_cx;
    cell_in.cy = c_cy;
    cell_in.cz = c_cz;
    cell_in.hold = c_hold;
    cell_in.rem = RW'(c_sqx) + RW'(c_sqy);
    cell_in.root = '0;
  end

  assign cch[0] = cell_in;

  for (genvar i = 0; i < SQRT_BITS; i++) begin : g_cell
    swk_cell u_cell (
      .clk(clk),
      .rst(rst),
      .stage(STW'(i)),
      .rot_en(i < CORDIC_STAGES),
      .din(cch[i]),
      .dout(cch[i+1])
    );
  end

  // stage p: mount negation, wrap, fold and clamp
  cell_t cend;
  logic signed [ZW-1:0] t;
  logic rev;

  assign cend = cch[SQRT_BITS];

  always_comb begin
    t = -cend.cz;
    if (t > DEG180) begin
      t = t - DEG360;
    end else if (t <= -DEG180) begin
      t = t + DEG360;
    end
    rev = 1'b0;
    if (t > DEG90) begin
      t = t - DEG180;
      rev = 1'b1;
    end else if (t < -DEG90) begin
      t = t + DEG180;
      rev = 1'b1;
    end
    if (t > DEG90) begin
      t = DEG90;
    end
    if (t < -DEG90) begin
      t = -DEG90;
    end
  end

  logic p_vld;
  logic [1:0] p_wheel;
  logic signed [ZW-1:0] p_t;
  logic p_rev;
  logic [SQRT_BITS-1:0] p_speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= cend.vld;
    end
  end

  always_ff @(posedge clk) begin
    p_wheel <= cend.wheel;
    p_t <= t;
    p_rev <= rev;
    p_speed <= cend.root;
  end

  // stage g: steps product, centidegrees, pulse dividend
  logic signed [ZW-1:0] tabs;
  logic [30:0] cdeg_sum;
  logic [FW-1:0] num;
  logic signed [13:0] span, base;
  logic [11:0] span_abs;
  logic over;
  div_t g_div;

  always_comb begin
    tabs = (p_t < 0) ? -p_t : p_t;
    cdeg_sum = 31'(tabs[22:0]) * 31'd100 + 31'd32768;
    over = (33'(p_speed) * 33'd100) > 33'(full_u);
    num = (p_speed < SQRT_BITS'(full_u)) ? p_speed[FW-1:0] : full_u;
    if (p_rev) begin
      span = $signed({3'b0, centre}) - $signed({5'b0, dead}) - $signed({3'b0, lowest});
      base = $signed({3'b0, centre}) - $signed({5'b0, dead});
    end else begin
      span = $signed({2'b0, highest}) - $signed({3'b0, centre}) - $signed({5'b0, dead});
      base = $signed({3'b0, centre}) + $signed({5'b0, dead});
    end
    span_abs = (span < 0) ? 12'(-span) : span[11:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_div.vld <= 1'b0;
    end else begin
      g_div.vld <= p_vld;
      g_div.res.wheel <= p_wheel;
      g_div.res.rev <= p_rev;
      g_div.res.tneg <= (p_t < 0);
      g_div.res.sprod <= PW'(tabs[22:0]) * PW'(steps_q8);
      g_div.res.cdeg_mag <= cdeg_sum[29:16];
      g_div.res.over <= over;
      g_div.res.span_neg <= (span < 0);
      g_div.res.base <= base;
      g_div.rem <= DVW'(num) * DVW'(span_abs);
      g_div.quo <= '0;
    end
  end

  // divider row, one quotient bit per cell
  div_t dch [0:DIV_BITS];

  assign dch[0] = g_div;

  for (genvar j = 0; j < DIV_BITS; j++) begin : g_div_cell
    swk_div_cell u_div (
      .clk(clk),
      .rst(rst),
      .bit_idx(DBW'(DIV_BITS - 1 - j)),
      .divisor(full_u),
      .din(dch[j]),
      .dout(dch[j+1])
    );
  end

  // output stage
  div_t dend;
  logic signed [13:0] term;
  logic signed [15:0] pulse;
  logic [16:0] smag;
  logic [15:0] smag_sat;

  assign dend = dch[DIV_BITS];

  always_comb begin
    term = dend.res.span_neg ? -$signed({2'b0, dend.quo}) : $signed({2'b0, dend.quo});
    if (!dend.res.over) begin
      pulse = $signed({5'b0, centre});
    end else if (dend.res.rev) begin
      pulse = 16'(dend.res.base) - 16'(term);
    end else begin
      pulse = 16'(dend.res.base) + 16'(term);
    end
    smag = dend.res.sprod[PW-1:24];
    smag_sat = (smag > 17'd32767) ? 16'd32767 : smag[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= dend.vld;
    end
  end

  always_ff @(posedge clk) begin
    wheel_index <= dend.res.wheel;
    last_wheel <= (dend.res.wheel == 2'd3);
    steer_target_steps <= dend.res.tneg ? -$signed(smag_sat) : $signed(smag_sat);
    steer_angle_cdeg <= dend.res.tneg ? -$signed(15'(dend.res.cdeg_mag))
                                      : $signed(15'(dend.res.cdeg_mag));
    if (pulse < 0) begin
      drive_pulse_us <= 12'd0;
    end else if (pulse > 16'sd4095) begin
      drive_pulse_us <= 12'd4095;
    end else begin
      drive_pulse_us <= pulse[11:0];
    end
    drive_reversed <= dend.res.rev;
  end

  // a command's four wheels leave back to back
  `SWK_ASSERT_NXT(a_wheel_seq, strobe && wheel_index != 2'd3, strobe && wheel_index == 2'($past(wheel_index) + 2'd1), "wheel results not consecutive")
  `SWK_ASSERT_IMP(a_last_flag, strobe, last_wheel == (wheel_index == 2'd3), "last_wheel mismatch")
  `SWK_ASSERT_NXT(a_busy_after, start && !busy, busy, "busy not raised after transaction")

endmodule
`default_nettype wire
